// File: rtl/mbi_pkg.sv
// ----------------------------------------------------------------------------
// mbi_pkg
// Shared types and constants of the masked bit interleaver: transaction
// payloads, opcodes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package mbi_pkg;

   localparam int WORD_LEN  = 64;
   localparam int HALF_LEN  = 32;
   // A rank counts selected positions below a bit, at most the full word.
   localparam int RANK_BITS = 7;
   localparam int HALF_IDX_BITS = 5;

   localparam logic [WORD_LEN-1:0] POSITION_MASK_RESET = 64'h5555_5555_5555_5555;
   localparam logic                SWAP_SIDES_RESET    = 1'b1;

   typedef enum logic {
      OP_INTERLEAVE   = 1'b0,
      OP_DEINTERLEAVE = 1'b1
   } opcode_type;

   typedef enum logic {
      CSR_POSITION_MASK = 1'b0,
      CSR_SWAP_SIDES    = 1'b1
   } csr_index_type;

   typedef struct packed {
      opcode_type            opcode;
      logic [HALF_LEN-1:0]   left_in;
      logic [HALF_LEN-1:0]   right_in;
      logic [WORD_LEN-1:0]   word_in;
   } req_type;

   typedef struct packed {
      logic [WORD_LEN-1:0]   word_out;
      logic [HALF_LEN-1:0]   left_out;
      logic [HALF_LEN-1:0]   right_out;
   } rsp_type;

endpackage

// File: rtl/masked_bit_interleave.sv
// ----------------------------------------------------------------------------
// masked_bit_interleave
// Mask-steered bit interleaver and deinterleaver with a two-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction carries an opcode and operands on req_data. Opcode
//   interleave deposits left_in and right_in into the positions of each side
//   and returns the combined word; opcode deinterleave splits word_in into
//   the left and right bits. Each request gives exactly one response on
//   rsp_data, in order.
//   The sides are set by the position mask and swap registers, written
//   through csr_write, csr_index and csr_wdata while no transaction is in
//   flight. A write takes effect for requests accepted from the next cycle.
//   A request passes through the input register, then the deposit and
//   extract network into the result register, which drives rsp_valid.
//   Throughput is one transaction per cycle while rsp_stall is low, set by
//   the single pass through that network.
//   When rsp_stall holds a response, the input register still takes one more
//   request; req_stall rises only when both registers are full.
//   Synchronous reset empties the pipeline and restores the register reset
//   values; the rank table has no reset and settles in the cycle after.
// ----------------------------------------------------------------------------
module masked_bit_interleave
   import mbi_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_write,
   input  csr_index_type       csr_index,
   input  logic [WORD_LEN-1:0] csr_wdata
);

   logic [WORD_BITS-1:0]                 mask_ff;
   logic [WORD_BITS-1:0]                 mask_in;
   logic                                 swap_ff;
   logic                                 swap_in;
   logic [WORD_BITS-1:0]                 left_sel;
   logic [WORD_BITS-1:0][RANK_BITS-1:0]  left_rank;

   logic                                 s1_valid_ff;
   logic                                 s1_valid_in;
   req_type                              s1_data_ff;
   logic                                 out_valid_ff;
   logic                                 out_valid_in;
   rsp_type                              out_data_ff;
   rsp_type                              result;

   logic                                 advance;
   logic                                 req_accept;

   always_comb begin
      mask_in = mask_ff;
      swap_in = swap_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_POSITION_MASK: mask_in = csr_wdata[WORD_BITS-1:0];
            CSR_SWAP_SIDES:    swap_in = csr_wdata[0];
            default: begin
               mask_in = mask_ff;
               swap_in = swap_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= POSITION_MASK_RESET[WORD_BITS-1:0];
         swap_ff <= SWAP_SIDES_RESET;
      end else begin
         mask_ff <= mask_in;
         swap_ff <= swap_in;
      end
   end

   assign left_sel = swap_ff ? mask_ff : ~mask_ff;

   mbi_rank #(
      .WORD_BITS (WORD_BITS)
   ) u_rank (
      .clock        (clock),
      .left_sel     (left_sel),
      .left_rank_ff (left_rank)
   );

   // The result register moves whenever it is empty or being taken.
   assign advance    = !out_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
      if (advance && s1_valid_ff) begin
         out_data_ff <= result;
      end
   end

   mbi_permute #(
      .WORD_BITS (WORD_BITS)
   ) u_permute (
      .req       (s1_data_ff),
      .left_sel  (left_sel),
      .left_rank (left_rank),
      .rsp       (result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: rtl/mbi_rank.sv
// ----------------------------------------------------------------------------
// mbi_rank
// Registered rank table: for every word position, the number of left side
// positions below it, built by a parallel prefix count over the select mask.
// ----------------------------------------------------------------------------
module mbi_rank
   import mbi_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  logic                                 clock,
   input  logic [WORD_BITS-1:0]                 left_sel,
   output logic [WORD_BITS-1:0][RANK_BITS-1:0]  left_rank_ff
);

   localparam int LEVELS = $clog2(WORD_BITS);

   logic [LEVELS:0][WORD_BITS-1:0][RANK_BITS-1:0] scan;
   logic [WORD_BITS-1:0][RANK_BITS-1:0]           left_rank_in;

   // Each level adds the partial count from a distance twice the last one.
   always_comb begin
      for (int p = 0; p < WORD_BITS; p++) begin
         scan[0][p] = RANK_BITS'(left_sel[p]);
      end
      for (int lv = 0; lv < LEVELS; lv++) begin
         for (int p = 0; p < WORD_BITS; p++) begin
            if (p >= (1 << lv)) begin
               scan[lv+1][p] = scan[lv][p] + scan[lv][p - (1 << lv)];
            end else begin
               scan[lv+1][p] = scan[lv][p];
            end
         end
      end
      for (int p = 0; p < WORD_BITS; p++) begin
         left_rank_in[p] = scan[LEVELS][p] - RANK_BITS'(left_sel[p]);
      end
   end

   // The table follows the registers in the cycle after; the user must change
   // them only while no transaction is in flight, as the block does not enforce it.
   always_ff @(posedge clock) begin
      left_rank_ff <= left_rank_in;
   end

endmodule

// File: rtl/mbi_permute.sv
// ----------------------------------------------------------------------------
// mbi_permute
// Deposit and extract network: steers operand bits into the word positions
// of each side, or gathers each side's bits out of a word, by rank.
// ----------------------------------------------------------------------------
module mbi_permute
   import mbi_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  req_type                              req,
   input  logic [WORD_BITS-1:0]                 left_sel,
   input  logic [WORD_BITS-1:0][RANK_BITS-1:0]  left_rank,
   output rsp_type                              rsp
);

   logic [WORD_LEN-1:0]  deposit_word;
   logic [HALF_LEN-1:0]  gather_left;
   logic [HALF_LEN-1:0]  gather_right;
   logic [RANK_BITS-1:0] lr;
   logic [RANK_BITS-1:0] rr;

   // Right side positions are the complement, so their rank is the position
   // minus the left rank.
   always_comb begin
      deposit_word = '0;
      gather_left  = '0;
      gather_right = '0;
      for (int p = 0; p < WORD_BITS; p++) begin
         lr = left_rank[p];
         rr = RANK_BITS'(p) - lr;
         if (left_sel[p]) begin
            if (lr < RANK_BITS'(HALF_LEN)) begin
               deposit_word[p] = req.left_in[lr[HALF_IDX_BITS-1:0]];
            end
         end else begin
            if (rr < RANK_BITS'(HALF_LEN)) begin
               deposit_word[p] = req.right_in[rr[HALF_IDX_BITS-1:0]];
            end
         end
         for (int k = 0; k < HALF_LEN; k++) begin
            if (left_sel[p] && (lr == RANK_BITS'(k))) begin
               gather_left[k] = gather_left[k] | req.word_in[p];
            end
            if (!left_sel[p] && (rr == RANK_BITS'(k))) begin
               gather_right[k] = gather_right[k] | req.word_in[p];
            end
         end
      end
   end

   always_comb begin
      rsp = '0;
      case (req.opcode)
         OP_INTERLEAVE: begin
            rsp.word_out = deposit_word;
         end
         OP_DEINTERLEAVE: begin
            rsp.left_out  = gather_left;
            rsp.right_out = gather_right;
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

endmodule

// File: rtl/mbi_checker.sv
// ----------------------------------------------------------------------------
// mbi_checker
// Port-level checks of the masked bit interleaver, bound to the top level.
// ----------------------------------------------------------------------------
module mbi_checker
   import mbi_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  req_type             req_data,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  rsp_type             rsp_data
);

   // A held response keeps its contents until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
   else $error("mbi: stalled response changed");

   // A stalled request stays offered and unchanged until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
   else $error("mbi: stalled request changed");

   // Requests are held back only while a response is blocked downstream.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
   else $error("mbi: request stalled without downstream backpressure");

   // A response never carries both an interleaved word and extracted halves.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.word_out == '0)
                    || ((rsp_data.left_out == '0) && (rsp_data.right_out == '0)))
   else $error("mbi: response mixes interleave and deinterleave fields");

   // Reset leaves the pipeline empty.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
   else $error("mbi: pipeline not empty after reset");

endmodule

bind masked_bit_interleave mbi_checker u_mbi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
